@@ sv/rcp_pkg.sv @@
// Shared types and constants of the rectangle canvas painter.
// Holds the item and result structs, the microcode word and its control ROM.
// Depends on nothing; rcp_seq, rcp_dpath and the top level import it.
`default_nettype none

package rcp_pkg;

	localparam int FX_FRAC = 8;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_RECT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHAPE = 2'd1;
	localparam logic [1:0] ST_SIZE  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BG     = 2'd2;

	localparam logic [7:0] SHAPE_FILLED  = 8'h52;
	localparam logic [7:0] SHAPE_OUTLINE = 8'h72;

	typedef struct packed {
		logic [1:0]         op;
		logic [7:0]         shape;
		logic signed [19:0] left;
		logic signed [19:0] top;
		logic signed [19:0] rect_width;
		logic signed [19:0] rect_height;
		logic [7:0]         paint_char;
		logic [9:0]         read_col;
		logic [9:0]         read_row;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] cell_value;
	} result_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_ACCEPT,
		A_OK,
		A_CLEAR,
		A_CHECK,
		A_SETUP,
		A_PAINT,
		A_READ,
		A_CELL,
		A_PRESENT
	} act_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_NEVER,
		C_NO_INPUT,
		C_OP_CLEAR,
		C_OP_RECT,
		C_OP_READ,
		C_CLR_MORE,
		C_CHECK_ERR,
		C_EMPTY,
		C_PAINT_MORE,
		C_RANGE_ERR,
		C_OUT_STALL
	} cond_t;

	typedef struct packed {
		act_t       act;
		cond_t      cond;
		logic [3:0] target;
	} ucode_t;

	typedef struct packed {
		logic no_input;
		logic op_clear;
		logic op_rect;
		logic op_read;
		logic clr_more;
		logic check_err;
		logic empty;
		logic paint_more;
		logic range_err;
		logic out_stall;
	} flags_t;

	// Entry points of the microprogram.
	localparam logic [3:0] U_IDLE  = 4'd0;
	localparam logic [3:0] U_CLEAR = 4'd5;
	localparam logic [3:0] U_RECT  = 4'd7;
	localparam logic [3:0] U_PAINT = 4'd10;
	localparam logic [3:0] U_READ  = 4'd12;
	localparam logic [3:0] U_OUT   = 4'd14;

	// A step jumps to target when its condition holds, else goes to the next step.
	function automatic ucode_t ucode_rom(input logic [3:0] pc);
		ucode_t w;
		case (pc)
			4'd0:  w = '{A_ACCEPT,  C_NO_INPUT,   U_IDLE};
			4'd1:  w = '{A_NONE,    C_OP_CLEAR,   U_CLEAR};
			4'd2:  w = '{A_NONE,    C_OP_RECT,    U_RECT};
			4'd3:  w = '{A_NONE,    C_OP_READ,    U_READ};
			4'd4:  w = '{A_OK,      C_ALWAYS,     U_OUT};
			4'd5:  w = '{A_CLEAR,   C_CLR_MORE,   U_CLEAR};
			4'd6:  w = '{A_OK,      C_ALWAYS,     U_OUT};
			4'd7:  w = '{A_CHECK,   C_CHECK_ERR,  U_OUT};
			4'd8:  w = '{A_SETUP,   C_NEVER,      U_IDLE};
			4'd9:  w = '{A_NONE,    C_EMPTY,      U_OUT};
			4'd10: w = '{A_PAINT,   C_PAINT_MORE, U_PAINT};
			4'd11: w = '{A_NONE,    C_ALWAYS,     U_OUT};
			4'd12: w = '{A_READ,    C_RANGE_ERR,  U_OUT};
			4'd13: w = '{A_CELL,    C_ALWAYS,     U_OUT};
			4'd14: w = '{A_PRESENT, C_OUT_STALL,  U_OUT};
			4'd15: w = '{A_NONE,    C_ALWAYS,     U_IDLE};
			default: w = '{A_NONE,  C_ALWAYS,     U_IDLE};
		endcase
		return w;
	endfunction

	// Fixed point to integer, truncating toward zero.
	function automatic logic signed [12:0] fx_trunc(input logic signed [20:0] v);
		logic signed [12:0] fl;
		fl = v[20:FX_FRAC];
		if (v[20] && (v[FX_FRAC-1:0] != '0)) begin
			fl = fl + 13'sd1;
		end
		return fl;
	endfunction

endpackage

`default_nettype wire

@@ sv/rcp_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rcp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/rcp_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jump select.
// Depends on rcp_pkg for the control word, conditions and the ROM.
`default_nettype none

module rcp_seq
	import rcp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire flags_t flags,
	output ucode_t      ctrl
);

	logic [3:0] pc_q;
	logic       taken;

	assign ctrl = ucode_rom(pc_q);

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS:     taken = 1'b1;
			C_NEVER:      taken = 1'b0;
			C_NO_INPUT:   taken = flags.no_input;
			C_OP_CLEAR:   taken = flags.op_clear;
			C_OP_RECT:    taken = flags.op_rect;
			C_OP_READ:    taken = flags.op_read;
			C_CLR_MORE:   taken = flags.clr_more;
			C_CHECK_ERR:  taken = flags.check_err;
			C_EMPTY:      taken = flags.empty;
			C_PAINT_MORE: taken = flags.paint_more;
			C_RANGE_ERR:  taken = flags.range_err;
			C_OUT_STALL:  taken = flags.out_stall;
			default:      taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= U_IDLE;
		end else begin
			pc_q <= taken ? ctrl.target : pc_q + 4'd1;
		end
	end

endmodule

`default_nettype wire

@@ sv/rcp_dpath.sv @@
// Datapath of the painter: configuration registers, item and edge registers,
// cell counters and the canvas RAM. Depends on rcp_pkg and rcp_ram.
`default_nettype none

module rcp_dpath
	import rcp_pkg::*;
#(
	parameter int MAX_SIDE = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ucode_t     ctrl,
	output flags_t          flags,
	input  wire logic       cfg_valid,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire logic       item_valid,
	input  wire item_t      item,
	output logic            item_stall,
	output logic            result_valid,
	input  wire logic       result_stall,
	output result_t         result
);

	localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [10:0] MAX_SIDE_W = 11'(MAX_SIDE);

	logic [8:0] cw_q, ch_q;
	logic [7:0] bg_q;
	item_t      item_q;
	logic [1:0] status_q;
	logic [7:0] cell_q;

	logic signed [12:0] x0_q, y0_q, xl_q, yl_q, xs_q, ys_q, xm_q, ym_q;
	logic [9:0]         col_q, row_q;
	logic [AW-1:0]      clr_q;

	logic [8:0]         cw_eff, ch_eff;
	logic               shape_bad, size_bad, range_err;
	logic signed [20:0] lx, ty, xe_sum, ye_sum, xl_sum, yl_sum;
	logic signed [12:0] x0, y0, xe, ye, cw13, ch13;
	logic signed [12:0] col13, row13, coln13, rown13;
	logic [9:0]         col_nxt, row_nxt;
	logic               col_last, row_last, on_edge;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	// A dimension register above the canvas size acts as the canvas size.
	assign cw_eff = ({2'b00, cw_q} > MAX_SIDE_W) ? MAX_SIDE_W[8:0] : cw_q;
	assign ch_eff = ({2'b00, ch_q} > MAX_SIDE_W) ? MAX_SIDE_W[8:0] : ch_q;
	assign cw13   = $signed({4'b0000, cw_eff});
	assign ch13   = $signed({4'b0000, ch_eff});

	assign shape_bad = (item_q.shape != SHAPE_FILLED) && (item_q.shape != SHAPE_OUTLINE);
	assign size_bad  = (item_q.rect_width <= 20'sd0) || (item_q.rect_height <= 20'sd0);
	assign range_err = (item_q.read_col >= {1'b0, cw_eff}) ||
	                   (item_q.read_row >= {1'b0, ch_eff});

	// Rectangle edges; the sums are exact in 21 bits.
	assign lx     = {item_q.left[19], item_q.left};
	assign ty     = {item_q.top[19], item_q.top};
	assign xe_sum = lx + {item_q.rect_width[19], item_q.rect_width};
	assign ye_sum = ty + {item_q.rect_height[19], item_q.rect_height};
	assign xl_sum = xe_sum - 21'sd256;
	assign yl_sum = ye_sum - 21'sd256;
	assign x0     = fx_trunc(lx);
	assign y0     = fx_trunc(ty);
	assign xe     = fx_trunc(xe_sum);
	assign ye     = fx_trunc(ye_sum);

	// Scan position within the clipped box.
	assign col_nxt  = col_q + 10'd1;
	assign row_nxt  = row_q + 10'd1;
	assign col13    = $signed({3'b000, col_q});
	assign row13    = $signed({3'b000, row_q});
	assign coln13   = $signed({3'b000, col_nxt});
	assign rown13   = $signed({3'b000, row_nxt});
	assign col_last = coln13 >= xm_q;
	assign row_last = rown13 >= ym_q;
	assign on_edge  = (item_q.shape == SHAPE_FILLED) || (col13 == x0_q) ||
	                  (row13 == y0_q) || (col13 == xl_q) || (row13 == yl_q);

	always_comb begin
		flags.no_input   = !item_valid;
		flags.op_clear   = item_q.op == OP_CLEAR;
		flags.op_rect    = item_q.op == OP_RECT;
		flags.op_read    = item_q.op == OP_READ;
		flags.clr_more   = clr_q != '1;
		flags.check_err  = shape_bad || size_bad;
		flags.empty      = (xs_q >= xm_q) || (ys_q >= ym_q);
		flags.paint_more = !(col_last && row_last);
		flags.range_err  = range_err;
		flags.out_stall  = result_stall;
	end

	assign item_stall   = ctrl.act != A_ACCEPT;
	assign result_valid = ctrl.act == A_PRESENT;
	assign result       = '{status: status_q, cell_value: cell_q};

	// Canvas port control.
	always_comb begin
		we    = 1'b0;
		waddr = {row_q[CW-1:0], col_q[CW-1:0]};
		wdata = item_q.paint_char;
		if (ctrl.act == A_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = bg_q;
		end else if (ctrl.act == A_PAINT) begin
			we = on_edge;
		end
	end

	assign re    = (ctrl.act == A_READ) && !range_err;
	assign raddr = {item_q.read_row[CW-1:0], item_q.read_col[CW-1:0]};

	rcp_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_canvas (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q  <= 9'd256;
			ch_q  <= 9'd256;
			bg_q  <= 8'd32;
			clr_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_WIDTH:  cw_q <= cfg_data;
					CFG_HEIGHT: ch_q <= cfg_data;
					CFG_BG:     bg_q <= cfg_data[7:0];
					default:    ;
				endcase
			end
			if (ctrl.act == A_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.act)
			A_ACCEPT: begin
				if (item_valid) begin
					item_q <= item;
				end
			end
			A_OK: begin
				status_q <= ST_OK;
				cell_q   <= '0;
			end
			A_CHECK: begin
				status_q <= shape_bad ? ST_SHAPE : (size_bad ? ST_SIZE : ST_OK);
				cell_q   <= '0;
			end
			A_SETUP: begin
				x0_q  <= x0;
				y0_q  <= y0;
				xl_q  <= fx_trunc(xl_sum);
				yl_q  <= fx_trunc(yl_sum);
				xs_q  <= x0[12] ? '0 : x0;
				ys_q  <= y0[12] ? '0 : y0;
				xm_q  <= (xe < cw13) ? xe : cw13;
				ym_q  <= (ye < ch13) ? ye : ch13;
				col_q <= x0[12] ? '0 : x0[9:0];
				row_q <= y0[12] ? '0 : y0[9:0];
			end
			A_PAINT: begin
				if (col_last) begin
					col_q <= xs_q[9:0];
					row_q <= row_nxt;
				end else begin
					col_q <= col_nxt;
				end
			end
			A_READ: begin
				status_q <= range_err ? ST_RANGE : ST_OK;
				cell_q   <= '0;
			end
			A_CELL: begin
				if (!range_err) begin
					cell_q <= rdata;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/rectangle_canvas_painter_core.sv @@
// Top level of the rectangle canvas painter.
// Depends on rcp_pkg, rcp_seq, rcp_dpath and, through it, rcp_ram.
`default_nettype none

// The painter keeps a byte canvas of MAX_SIDE by MAX_SIDE cells in one RAM and
// handles one item at a time under a small microprogram. An item is taken when
// item_valid is high and item_stall is low; its single result is offered on
// result_valid and stays until a transfer with result_stall low. A clear writes
// every RAM word, one a cycle. A rectangle visits each cell of its box clipped
// to the canvas, one a cycle, and writes those that it paints; the canvas RAM
// takes one cell write per cycle. An empty clipped box and a rejected rectangle
// write nothing. A read inside the canvas goes through the registered read port
// of the canvas RAM; a read outside the canvas and the unused op do not read it.
// Coordinates are signed fixed point with eight fraction bits, and edges are
// found by truncating toward zero. The configuration port is always ready and
// should be written only while no item is in flight; a width or height above
// MAX_SIDE acts as MAX_SIDE. Cells never written read back as arbitrary values.
module rectangle_canvas_painter_core
	import rcp_pkg::*;
#(
	parameter int MAX_SIDE = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [8:0] cfg_data,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire item_t      item,
	output logic            result_valid,
	input  wire logic       result_stall,
	output result_t         result
);

	ucode_t ctrl;
	flags_t flags;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	// The sequencer steps through the control ROM and picks jumps from the flags.
	rcp_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.ctrl  (ctrl)
	);

	// The datapath does what each control word asks and reports the flags.
	rcp_dpath #(
		.MAX_SIDE(MAX_SIDE)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.flags       (flags),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item        (item),
		.item_stall  (item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

`default_nettype wire
